### design/bdl_pkg.sv
// shared constants, codes and types for the bounded deque list engine
// used by bdl_cell, bdl_chain and bounded_deque_list_engine
package bdl_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  localparam int LENGTH_W = 5;
  localparam int COUNT_W  = 8;
  localparam int CMP_W    = (LEN_W > COUNT_W) ? LEN_W : COUNT_W;

  // operation codes carried by each input word
  localparam logic [3:0] MODE_PUSH_FRONT   = 4'd0;
  localparam logic [3:0] MODE_PUSH_BACK    = 4'd1;
  localparam logic [3:0] MODE_POP_FRONT    = 4'd2;
  localparam logic [3:0] MODE_POP_BACK     = 4'd3;
  localparam logic [3:0] MODE_DUMP         = 4'd4;
  localparam logic [3:0] MODE_DROP_LAST    = 4'd5;
  localparam logic [3:0] MODE_REMOVE_2ND   = 4'd6;
  localparam logic [3:0] MODE_APPEND_LEN   = 4'd7;
  localparam logic [3:0] MODE_APPEND_RUN   = 4'd8;
  localparam logic [3:0] MODE_INSERT_LAST  = 4'd9;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  // per-cycle command broadcast along the row of cells
  localparam logic [2:0] CELL_HOLD       = 3'd0;
  localparam logic [2:0] CELL_FROM_LEFT  = 3'd1;
  localparam logic [2:0] CELL_FROM_RIGHT = 3'd2;
  localparam logic [2:0] CELL_ROTATE     = 3'd3;
  localparam logic [2:0] CELL_DROP_FIRST = 3'd4;
  localparam logic [2:0] CELL_WRITE      = 3'd5;
  localparam logic [2:0] CELL_INSERT     = 3'd6;

  typedef struct packed {
    logic [2:0]        op;
    logic [LEN_W-1:0]  pos;
    logic [DATA_W-1:0] wdata;
  } cell_ctl_t;

endpackage

### design/bounded_deque_list_engine.sv
// Bounded deque of signed 32-bit entries held in a row of cells, the front entry in the
// first cell; every operation moves the whole row by at most one position per cycle.
// Push, pop, drop, remove-second, append-length and insert-before-last finish in the
// cycle the word is taken, so one word per cycle is accepted while results are taken.
// A dump emits the stored entries one by one from the front, rotating the row once round
// so that the contents end where they started; an append of 1..N writes the values 1 to N
// at the back one at a time, ending with a full status if it meets a full store.
// No clearing pass after reset.
// depends on bdl_pkg and bdl_chain
module bounded_deque_list_engine (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [3:0]                          mode,
  input  logic signed [bdl_pkg::DATA_W-1:0]   value,
  input  logic [bdl_pkg::COUNT_W-1:0]         count,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [bdl_pkg::DATA_W-1:0]   element,
  output logic                                last_of_run,
  output logic [bdl_pkg::LENGTH_W-1:0]        length,
  output logic [1:0]                          status
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DUMP = 2'd1;
  localparam logic [1:0] ST_BULK = 2'd2;

  localparam logic [bdl_pkg::LEN_W-1:0] FULL_LEN = bdl_pkg::LEN_W'(bdl_pkg::CAPACITY);

  logic [1:0]                    state, state_next;
  logic [bdl_pkg::LEN_W-1:0]     fill, fill_next;
  logic [bdl_pkg::LEN_W-1:0]     dump_left, dump_left_next;
  logic [bdl_pkg::COUNT_W-1:0]   bulk_val, bulk_val_next;
  logic [bdl_pkg::COUNT_W-1:0]   bulk_n, bulk_n_next;

  bdl_pkg::cell_ctl_t            ctl;
  logic [bdl_pkg::DATA_W-1:0]    head;

  logic                          accept, out_free, load;
  logic [bdl_pkg::DATA_W-1:0]    o_elem;
  logic                          o_last;
  logic [1:0]                    o_status;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  bdl_chain u_chain (
    .clk  (clk),
    .ctl  (ctl),
    .head (head)
  );

  always_comb begin
    state_next     = state;
    fill_next      = fill;
    dump_left_next = dump_left;
    bulk_val_next  = bulk_val;
    bulk_n_next    = bulk_n;
    ctl.op         = bdl_pkg::CELL_HOLD;
    ctl.pos        = fill;
    ctl.wdata      = value;
    load           = 1'b0;
    o_elem         = '0;
    o_last         = 1'b1;
    o_status       = bdl_pkg::STATUS_DONE;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          load = 1'b1;
          case (mode)
            bdl_pkg::MODE_PUSH_FRONT: begin
              if (fill == FULL_LEN) begin
                o_status = bdl_pkg::STATUS_FULL;
              end else begin
                ctl.op    = bdl_pkg::CELL_FROM_LEFT;
                fill_next = fill + 1'b1;
              end
            end
            bdl_pkg::MODE_PUSH_BACK: begin
              if (fill == FULL_LEN) begin
                o_status = bdl_pkg::STATUS_FULL;
              end else begin
                ctl.op    = bdl_pkg::CELL_WRITE;
                fill_next = fill + 1'b1;
              end
            end
            bdl_pkg::MODE_POP_FRONT: begin
              if (fill == '0) begin
                o_status = bdl_pkg::STATUS_EMPTY;
              end else begin
                ctl.op    = bdl_pkg::CELL_FROM_RIGHT;
                fill_next = fill - 1'b1;
              end
            end
            bdl_pkg::MODE_POP_BACK: begin
              if (fill == '0) begin
                o_status = bdl_pkg::STATUS_EMPTY;
              end else begin
                fill_next = fill - 1'b1;
              end
            end
            bdl_pkg::MODE_DUMP: begin
              if (fill == '0) begin
                o_status = bdl_pkg::STATUS_EMPTY;
              end else begin
                load           = 1'b0;
                state_next     = ST_DUMP;
                dump_left_next = fill;
              end
            end
            bdl_pkg::MODE_DROP_LAST: begin
              if (count == '0) begin
                o_status = bdl_pkg::STATUS_DONE;
              end else if (fill == '0) begin
                o_status = bdl_pkg::STATUS_EMPTY;
              end else if (bdl_pkg::CMP_W'(count) >= bdl_pkg::CMP_W'(fill)) begin
                fill_next = '0;
              end else begin
                fill_next = bdl_pkg::LEN_W'(fill - bdl_pkg::LEN_W'(count));
              end
            end
            bdl_pkg::MODE_REMOVE_2ND: begin
              if (fill < bdl_pkg::LEN_W'(2)) begin
                o_status = bdl_pkg::STATUS_EMPTY;
              end else begin
                ctl.op    = bdl_pkg::CELL_DROP_FIRST;
                fill_next = fill - 1'b1;
              end
            end
            bdl_pkg::MODE_APPEND_LEN: begin
              if (fill == FULL_LEN) begin
                o_status = bdl_pkg::STATUS_FULL;
              end else begin
                ctl.op    = bdl_pkg::CELL_WRITE;
                ctl.wdata = bdl_pkg::DATA_W'(fill);
                fill_next = fill + 1'b1;
              end
            end
            bdl_pkg::MODE_APPEND_RUN: begin
              if (count != '0) begin
                load          = 1'b0;
                state_next    = ST_BULK;
                bulk_val_next = bdl_pkg::COUNT_W'(1);
                bulk_n_next   = count;
              end
            end
            bdl_pkg::MODE_INSERT_LAST: begin
              if (fill < bdl_pkg::LEN_W'(2)) begin
                o_status = bdl_pkg::STATUS_EMPTY;
              end else if (fill == FULL_LEN) begin
                o_status = bdl_pkg::STATUS_FULL;
              end else begin
                ctl.op    = bdl_pkg::CELL_INSERT;
                ctl.pos   = fill - 1'b1;
                fill_next = fill + 1'b1;
              end
            end
            default: o_status = bdl_pkg::STATUS_DONE;
          endcase
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          load           = 1'b1;
          o_elem         = head;
          o_last         = (dump_left == bdl_pkg::LEN_W'(1));
          ctl.op         = bdl_pkg::CELL_ROTATE;
          ctl.pos        = fill - 1'b1;
          dump_left_next = dump_left - 1'b1;
          if (o_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_BULK: begin
        if (out_free) begin
          if (fill == FULL_LEN) begin
            load       = 1'b1;
            o_status   = bdl_pkg::STATUS_FULL;
            state_next = ST_IDLE;
          end else begin
            ctl.op    = bdl_pkg::CELL_WRITE;
            ctl.wdata = bdl_pkg::DATA_W'(bulk_val);
            fill_next = fill + 1'b1;
            if (bulk_val == bulk_n) begin
              load       = 1'b1;
              state_next = ST_IDLE;
            end else begin
              bulk_val_next = bulk_val + 1'b1;
            end
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      dump_left <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      dump_left <= dump_left_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result word and bulk counters carry no reset
  always_ff @(posedge clk) begin
    bulk_val <= bulk_val_next;
    bulk_n   <= bulk_n_next;
    if (load) begin
      element     <= o_elem;
      last_of_run <= o_last;
      length      <= bdl_pkg::LENGTH_W'(fill_next);
      status      <= o_status;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FULL_LEN)
    else $error("fill count above capacity");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    (accept && mode != bdl_pkg::MODE_DUMP && mode != bdl_pkg::MODE_APPEND_RUN)
      |=> (out_valid && last_of_run))
    else $error("single operation gave no final result");

  a_dump_keeps_fill: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DUMP) |=> (fill == $past(fill)))
    else $error("fill changed during dump");

  a_dump_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DUMP) |-> (dump_left != '0 && dump_left <= fill))
    else $error("dump counter out of range");

endmodule

### design/bdl_cell.sv
// one list position: holds a single entry and moves it to or from its neighbours
// depends on bdl_pkg
module bdl_cell (
  input  logic                           clk,
  input  bdl_pkg::cell_ctl_t             ctl,
  input  logic [bdl_pkg::IDX_W-1:0]      idx,
  input  logic [bdl_pkg::DATA_W-1:0]     left_data,
  input  logic [bdl_pkg::DATA_W-1:0]     right_data,
  input  logic [bdl_pkg::DATA_W-1:0]     head_data,
  output logic [bdl_pkg::DATA_W-1:0]     data
);

  logic [bdl_pkg::DATA_W-1:0] data_next;
  logic [bdl_pkg::LEN_W-1:0]  my_pos;
  logic [bdl_pkg::LEN_W-1:0]  pos_after;

  assign my_pos    = bdl_pkg::LEN_W'(idx);
  assign pos_after = bdl_pkg::LEN_W'(ctl.pos + 1'b1);

  always_comb begin
    data_next = data;
    case (ctl.op)
      bdl_pkg::CELL_FROM_LEFT:  data_next = left_data;
      bdl_pkg::CELL_FROM_RIGHT: data_next = right_data;
      bdl_pkg::CELL_ROTATE: begin
        // front entry wraps round to the last occupied position
        if (my_pos < ctl.pos) begin
          data_next = right_data;
        end else if (my_pos == ctl.pos) begin
          data_next = head_data;
        end
      end
      bdl_pkg::CELL_DROP_FIRST: begin
        if (my_pos != '0) begin
          data_next = right_data;
        end
      end
      bdl_pkg::CELL_WRITE: begin
        if (my_pos == ctl.pos) begin
          data_next = ctl.wdata;
        end
      end
      bdl_pkg::CELL_INSERT: begin
        if (my_pos == ctl.pos) begin
          data_next = ctl.wdata;
        end else if (my_pos == pos_after) begin
          data_next = left_data;
        end
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

### design/bdl_chain.sv
// row of bdl_cell instances, one per list position, front entry at position zero
// depends on bdl_pkg and bdl_cell
module bdl_chain (
  input  logic                        clk,
  input  bdl_pkg::cell_ctl_t          ctl,
  output logic [bdl_pkg::DATA_W-1:0]  head
);

  logic [bdl_pkg::DATA_W-1:0] cell_data [bdl_pkg::CAPACITY];

  assign head = cell_data[0];

  for (genvar g = 0; g < bdl_pkg::CAPACITY; g++) begin : g_cell
    logic [bdl_pkg::DATA_W-1:0] left_in;
    logic [bdl_pkg::DATA_W-1:0] right_in;

    // push front feeds the new word into the first cell
    if (g == 0) begin : g_first
      assign left_in = ctl.wdata;
    end else begin : g_mid_l
      assign left_in = cell_data[g-1];
    end

    if (g == bdl_pkg::CAPACITY - 1) begin : g_last
      assign right_in = cell_data[0];
    end else begin : g_mid_r
      assign right_in = cell_data[g+1];
    end

    bdl_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .idx        (bdl_pkg::IDX_W'(g)),
      .left_data  (left_in),
      .right_data (right_in),
      .head_data  (cell_data[0]),
      .data       (cell_data[g])
    );
  end

endmodule
